/* rtl/mbls_pkg.sv */
package mbls_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int MAX_REQ_LEN = 32;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int FILL_W = 9;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = $clog2(MAX_REQ_LEN);

    localparam logic [2:0] REQ_PUSH  = 3'd0;
    localparam logic [2:0] REQ_POP   = 3'd1;
    localparam logic [2:0] REQ_DROP  = 3'd2;
    localparam logic [2:0] REQ_PEEK  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [LEN_W-1:0] len;
        logic [7:0]       push_byte;
        logic             run_first;
        logic             run_last;
    } t_req;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  done_count;
        logic              overflow;
        logic              short_read;
        logic [FILL_W-1:0] fill_level;
        logic              result_last;
    } t_res;

endpackage

/* rtl/mbls_mem.sv */
module mbls_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [mbls_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                 i_wr_data,
    input  logic [mbls_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import mbls_pkg::*;

    logic [7:0] r_mem [STACK_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/multi_byte_lifo_stack.sv */
// Byte-wide LIFO stack with block push, pop, drop, peek and clear.
// Input channel: i_in_valid / o_in_ready carry one request beat in i_in_data.
// A push run is one beat per byte; the first beat's len is checked against
// the free space and an oversized run is rejected whole (overflow on that
// beat). Pop, drop and peek move up to len bytes (saturated to 32, clamped
// to the fill); pop and peek return one result beat per byte, lowest
// address first, the last one marked with result_last.
// Output channel: o_out_valid / i_out_ready carry result beats in
// o_out_data, held in an output register.
// Timing: the result of a push, drop, clear or empty read is registered
// and appears in the cycle after the request is taken; the first byte of
// a pop or peek passes through the memory's read register and then the
// output register. The stack memory's single registered read port
// delivers one byte per cycle while the receiver takes them.
// A stalled receiver holds the output register; the byte stream pauses and
// resumes without loss, and no new request is taken until it drains.
// Reset empties the stack and closes any open push run; stored bytes are
// not cleared.
module multi_byte_lifo_stack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mbls_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mbls_pkg::t_res  o_out_data
);
    import mbls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [FILL_W-1:0] r_top, n_top;
    logic              r_run, n_run;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_n, n_n;
    logic              r_shrt, n_shrt;
    t_res              r_out, n_out;
    logic              r_out_valid;

    logic              out_free;
    logic              in_acc;
    logic              out_ld;
    logic [LEN_W-1:0]  asked;
    logic [LEN_W-1:0]  req_n;
    logic [FILL_W-1:0] req_base;
    logic [FILL_W-1:0] free_space;
    logic              run_eff;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              is_read;
    logic              emit_last;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    // clamp the ask to the request limit, then to the fill
    assign asked      = (i_in_data.len > LEN_W'(MAX_REQ_LEN)) ? LEN_W'(MAX_REQ_LEN)
                                                               : i_in_data.len;
    assign req_n      = ({{(FILL_W-LEN_W){1'b0}}, asked} < r_top) ? asked
                                                                  : r_top[LEN_W-1:0];
    assign req_base   = r_top - {{(FILL_W-LEN_W){1'b0}}, req_n};
    assign free_space = FILL_W'(STACK_DEPTH) - r_top;
    assign run_eff    = i_in_data.run_first
                        ? ({{(FILL_W-LEN_W){1'b0}}, i_in_data.len} <= free_space)
                        : r_run;
    assign is_read    = (i_in_data.req_type == REQ_POP) || (i_in_data.req_type == REQ_PEEK);
    assign emit_last  = ({1'b0, r_cnt} + LEN_W'(1)) == r_n;
    assign wr_en      = in_acc && (i_in_data.req_type == REQ_PUSH) && run_eff
                        && (r_top < FILL_W'(STACK_DEPTH));

    always_comb begin
        n_state = r_state;
        n_top   = r_top;
        n_run   = r_run;
        n_base  = r_base;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_shrt  = r_shrt;
        n_out   = '0;
        out_ld  = 1'b0;
        rd_addr = req_base[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_out.fill_level  = r_top;
                n_out.result_last = 1'b1;
                if (in_acc) begin
                    out_ld = 1'b1;
                    n_run  = 1'b0;
                    case (i_in_data.req_type)
                        REQ_PUSH: begin
                            n_out.overflow   = i_in_data.run_first && !run_eff;
                            n_out.done_count = LEN_W'(wr_en);
                            if (wr_en) begin
                                n_top = r_top + FILL_W'(1);
                            end
                            n_out.fill_level = n_top;
                            n_run = run_eff && !i_in_data.run_last;
                        end
                        REQ_POP, REQ_DROP, REQ_PEEK: begin
                            n_out.done_count = req_n;
                            n_out.short_read = req_n < asked;
                            if (i_in_data.req_type != REQ_PEEK) begin
                                n_top = req_base;
                            end
                            n_out.fill_level = n_top;
                            // start the byte stream; the read is already issued
                            if (is_read && req_n != '0) begin
                                out_ld  = 1'b0;
                                n_state = S_EMIT;
                                n_base  = req_base[ADDR_W-1:0];
                                n_cnt   = '0;
                                n_n     = req_n;
                                n_shrt  = req_n < asked;
                            end
                        end
                        REQ_CLEAR: begin
                            n_top            = '0;
                            n_out.fill_level = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                n_out.out_byte    = rd_data;
                n_out.byte_valid  = 1'b1;
                n_out.done_count  = r_n;
                n_out.short_read  = r_shrt;
                n_out.fill_level  = r_top;
                n_out.result_last = emit_last;
                // re-read the same entry while stalled so the data holds
                rd_addr = r_base + ADDR_W'(r_cnt);
                if (out_free) begin
                    out_ld  = 1'b1;
                    rd_addr = r_base + ADDR_W'(r_cnt) + ADDR_W'(1);
                    n_cnt   = r_cnt + CNT_W'(1);
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    mbls_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_top[ADDR_W-1:0]),
        .i_wr_data (i_in_data.push_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_run   <= n_run;
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_cnt  <= n_cnt;
        r_n    <= n_n;
        r_shrt <= n_shrt;
        if (out_ld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= FILL_W'(STACK_DEPTH))
        else $error("fill level beyond stack depth");

    a_top_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_top))
        else $error("fill level moved without a request");

    a_stream_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_read && req_n != '0) |=> (r_state == S_EMIT))
        else $error("read request did not start the byte stream");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && emit_last) |=>
            (r_state == S_IDLE && o_out_valid && o_out_data.result_last))
        else $error("byte stream did not close on its last beat");

endmodule
